[src/bec_pkg.sv]
// Shared widths, register indexes and arc codes of the bounce easing curve block.
package bec_pkg;

  // default widths of the value and time fields
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned TIME_WIDTH_DEF  = 16;
  localparam int unsigned CFG_DATA_W_DEF  = 32;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EASE_IN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd5;

  // Q16.16 one, reset value of the end register
  localparam int Q_ONE = 65536;

  // normalized time u is Q16 in [0, 1]: 17 quotient bits
  localparam int unsigned U_FRAC = 16;
  localparam int unsigned U_W    = U_FRAC + 1;

  // 11*u and the signed arc offset error
  localparam int unsigned N11_W = 20;
  localparam int unsigned ERR_W = 22;
  localparam int unsigned MAG_W = 18;
  localparam int unsigned SQ_W  = 2 * MAG_W;

  // arc breakpoints on 11*u: 4/11, 8/11, 10/11 of full scale
  localparam logic [N11_W-1:0] BRK_1 = N11_W'(4 << U_FRAC);
  localparam logic [N11_W-1:0] BRK_2 = N11_W'(8 << U_FRAC);
  localparam logic [N11_W-1:0] BRK_3 = N11_W'(10 << U_FRAC);

  // arc centers expressed on 11*u (last arc on 22*u)
  localparam logic signed [ERR_W-1:0] CTR_ALT    = ERR_W'(2 << U_FRAC);
  localparam logic signed [ERR_W-1:0] CTR_SECOND = ERR_W'(6 << U_FRAC);
  localparam logic signed [ERR_W-1:0] CTR_THIRD  = ERR_W'(9 << U_FRAC);
  localparam logic signed [ERR_W-1:0] CTR_LAST   = ERR_W'(21 << U_FRAC);

  // square to Q30: right shifts for the three denominators
  localparam int unsigned SH_D4  = 4;
  localparam int unsigned SH_D16 = 6;
  localparam int unsigned SH_D64 = 8;

  // curve factor, signed Q30
  localparam int unsigned FRAC_F = 30;
  localparam int unsigned F_W    = FRAC_F + 2;
  localparam int unsigned FM_W   = FRAC_F + 1;
  localparam logic signed [F_W-1:0] F_ONE       = F_W'(longint'(1) << FRAC_F);
  localparam logic signed [F_W-1:0] F_QUARTER   = F_ONE >>> 2;
  localparam logic signed [F_W-1:0] F_SIXTEENTH = F_ONE >>> 4;
  localparam logic signed [F_W-1:0] F_SIXTYFOUR = F_ONE >>> 6;

  // which quadratic arc an item falls in
  typedef enum logic [2:0] {
    ARC_FIRST,
    ARC_FIRST_ALT,
    ARC_SECOND,
    ARC_THIRD,
    ARC_LAST
  } arc_e;

  // register stages from input to result: entry, divider, eight arithmetic stages
  localparam int unsigned PIPE_DEPTH = 1 + U_W + 8;

endpackage

[src/bec_if.sv]
// Channel interfaces of the bounce easing curve block: time in, value out, register writes.
interface bec_time_if #(
  parameter int unsigned TIME_WIDTH = bec_pkg::TIME_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] elapsed_time;

  modport source (output valid, output elapsed_time, input ready);
  modport sink   (input valid, input elapsed_time, output ready);
endinterface

interface bec_value_if #(
  parameter int unsigned VALUE_WIDTH = bec_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] eased_value;

  modport source (output valid, output eased_value, input ready);
  modport sink   (input valid, input eased_value, output ready);
endinterface

interface bec_cfg_if #(
  parameter int unsigned DATA_WIDTH = bec_pkg::CFG_DATA_W_DEF
);
  logic                           valid;
  logic                           ready;
  logic [bec_pkg::CFG_IDX_W-1:0]  index;
  logic [DATA_WIDTH-1:0]          wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[src/bounce_easing_curve_top.sv]
// Bounce easing curve: pipelined time-to-value evaluation of a four-arc bounce curve.
//
// Channels: in_ch carries one elapsed_time item (ms), out_ch returns one
// eased_value item (signed Q16.16, saturated) per input item, in order.
// cfg_ch writes the six registers (start, end, duration, ease_in,
// amplitude_enable, amplitude) by index; it is always ready. The user
// must write it only while no item is in flight; the block does not enforce this.
// Pipeline: entry stage, 17 restoring divider stages giving one quotient
// bit each, eight arithmetic stages. Throughput: one item per cycle while
// the skid register is empty.
// Output side: results leave from the last stage; a skid register catches
// the item that was on the output when the receiver stalled. While the skid
// register is full the whole pipeline holds and in_ch.ready is low, so each
// stalled cycle costs one input slot; nothing is lost or repeated.
// Reset: all valids clear, registers return to start 0, end 1.0,
// duration 1, bounce out, no amplitude override.
module bounce_easing_curve_top #(
  parameter int unsigned VALUE_WIDTH = bec_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH  = bec_pkg::TIME_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bec_time_if.sink     in_ch,
  bec_value_if.source  out_ch,
  bec_cfg_if.sink      cfg_ch
);

  localparam int unsigned VW     = VALUE_WIDTH;
  localparam int unsigned TW     = TIME_WIDTH;
  localparam int unsigned C_W    = VW + 1;          // swing and multiplier width
  localparam int unsigned MW     = C_W;             // multiplier magnitude width
  localparam int unsigned LO_W   = (MW + 1) / 2;    // low partial product slice
  localparam int unsigned HI_W   = MW - LO_W;
  localparam int unsigned FM_W   = bec_pkg::FM_W;
  localparam int unsigned PROD_W = MW + FM_W;
  localparam int unsigned V_W    = VW + 3;          // r and unsaturated value
  localparam int unsigned DEPTH  = bec_pkg::PIPE_DEPTH;
  localparam int unsigned U_W    = bec_pkg::U_W;
  localparam int unsigned U_FRAC = bec_pkg::U_FRAC;
  localparam int unsigned N11_W  = bec_pkg::N11_W;
  localparam int unsigned ERR_W  = bec_pkg::ERR_W;
  localparam int unsigned MAG_W  = bec_pkg::MAG_W;
  localparam int unsigned SQ_W   = bec_pkg::SQ_W;
  localparam int unsigned F_W    = bec_pkg::F_W;
  localparam int unsigned FRAC_F = bec_pkg::FRAC_F;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic signed [VW-1:0] start_q;
  logic signed [VW-1:0] end_q;
  logic signed [VW-1:0] amp_q;
  logic [TW-1:0]        dur_q;
  logic                 ease_q;
  logic                 amp_en_q;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      end_q    <= VW'(bec_pkg::Q_ONE);
      dur_q    <= TW'(1);
      ease_q   <= 1'b0;
      amp_en_q <= 1'b0;
      amp_q    <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        bec_pkg::REG_START:      start_q  <= cfg_ch.wdata[VW-1:0];
        bec_pkg::REG_END:        end_q    <= cfg_ch.wdata[VW-1:0];
        bec_pkg::REG_DURATION:   dur_q    <= cfg_ch.wdata[TW-1:0];
        bec_pkg::REG_EASE_IN:    ease_q   <= cfg_ch.wdata[0];
        bec_pkg::REG_AMP_ENABLE: amp_en_q <= cfg_ch.wdata[0];
        bec_pkg::REG_AMPLITUDE:  amp_q    <= cfg_ch.wdata[VW-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero duration acts as one
  logic [TW-1:0] dur_eff;
  assign dur_eff = (dur_q == '0) ? TW'(1) : dur_q;

  // ---------------------------------------------------------------
  // pipeline control: one advance enable, valids shift with the data
  // ---------------------------------------------------------------
  logic             en;
  logic             skid_vld_q;
  logic [DEPTH-1:0] vld_q;

  assign en          = !skid_vld_q;
  assign in_ch.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
    end
  end

  // ---------------------------------------------------------------
  // entry stage: clamp to duration, mirror in time for ease-in
  // ---------------------------------------------------------------
  logic [TW-1:0] tt_clamp;
  logic [TW-1:0] tt_mir;
  logic [TW-1:0] a_tt_q;

  assign tt_clamp = (in_ch.elapsed_time > dur_eff) ? dur_eff : in_ch.elapsed_time;
  assign tt_mir   = ease_q ? (dur_eff - tt_clamp) : tt_clamp;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_tt_q <= tt_mir;
    end
  end

  // ---------------------------------------------------------------
  // restoring divider, u = floor(tt * 2^16 / dur), one bit per stage
  // ---------------------------------------------------------------
  logic [TW-1:0]  div_rem_q [U_W];
  logic [U_W-1:0] div_quo_q [U_W];

  // top bit: tt never exceeds dur, so it is set only when they are equal
  always_ff @(posedge clk_i) begin
    if (en) begin
      div_rem_q[0] <= (a_tt_q == dur_eff) ? '0 : a_tt_q;
      div_quo_q[0] <= U_W'(a_tt_q == dur_eff);
    end
  end

  for (genvar k = 1; k < U_W; k++) begin : g_div
    logic [TW:0] rem2;
    logic [TW:0] diff;
    logic        ge;

    assign rem2 = {div_rem_q[k-1], 1'b0};
    assign diff = rem2 - {1'b0, dur_eff};
    assign ge   = (rem2 >= {1'b0, dur_eff});

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_rem_q[k] <= ge ? diff[TW-1:0] : rem2[TW-1:0];
        div_quo_q[k] <= {div_quo_q[k-1][U_W-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------
  // stage B: 11u, arc choice, offset from the arc center
  // ---------------------------------------------------------------
  logic [U_W-1:0]          u;
  logic [N11_W-1:0]        n11;
  logic signed [ERR_W-1:0] n11_s;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        err_abs;
  logic                    alt;
  bec_pkg::arc_e           arc;
  bec_pkg::arc_e           b_arc_q;
  logic [MAG_W-1:0]        b_mag_q;

  assign u     = div_quo_q[U_FRAC];
  assign n11   = (N11_W'(u) << 3) + (N11_W'(u) << 1) + N11_W'(u);
  assign n11_s = signed'(ERR_W'(n11));
  // zero swing with an override uses the alternate first arc
  assign alt   = (end_q == start_q) && amp_en_q;

  always_comb begin
    if (n11 < bec_pkg::BRK_1) begin
      arc = alt ? bec_pkg::ARC_FIRST_ALT : bec_pkg::ARC_FIRST;
      err = alt ? (n11_s - bec_pkg::CTR_ALT) : n11_s;
    end else if (n11 < bec_pkg::BRK_2) begin
      arc = bec_pkg::ARC_SECOND;
      err = n11_s - bec_pkg::CTR_SECOND;
    end else if (n11 < bec_pkg::BRK_3) begin
      arc = bec_pkg::ARC_THIRD;
      err = n11_s - bec_pkg::CTR_THIRD;
    end else begin
      arc = bec_pkg::ARC_LAST;
      err = (n11_s <<< 1) - bec_pkg::CTR_LAST;
    end
  end

  assign err_abs = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_arc_q <= arc;
      b_mag_q <= err_abs[MAG_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // stage C: square of the offset
  // ---------------------------------------------------------------
  bec_pkg::arc_e   c_arc_q;
  logic [SQ_W-1:0] c_sq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_arc_q <= b_arc_q;
      c_sq_q  <= SQ_W'(b_mag_q) * SQ_W'(b_mag_q);
    end
  end

  // ---------------------------------------------------------------
  // stage D: Q30 factor, multiplier and base selection
  // ---------------------------------------------------------------
  logic [SQ_W:0]         sq_ext;
  logic [SQ_W:0]         sq_d4;
  logic [SQ_W:0]         sq_d16;
  logic [SQ_W:0]         sq_d64;
  logic signed [F_W-1:0] f_val;
  logic signed [C_W-1:0] swing;
  logic signed [C_W-1:0] amp_sel;
  logic signed [C_W-1:0] mult_sel;
  logic signed [C_W-1:0] base_sel;
  logic signed [F_W-1:0] d_f_q;
  logic signed [C_W-1:0] d_mult_q;
  logic signed [C_W-1:0] d_base_q;

  // rounded to nearest, ties up
  assign sq_ext = (SQ_W + 1)'(c_sq_q);
  assign sq_d4  = (sq_ext + ((SQ_W + 1)'(1) << (bec_pkg::SH_D4 - 1))) >> bec_pkg::SH_D4;
  assign sq_d16 = (sq_ext + ((SQ_W + 1)'(1) << (bec_pkg::SH_D16 - 1))) >> bec_pkg::SH_D16;
  assign sq_d64 = (sq_ext + ((SQ_W + 1)'(1) << (bec_pkg::SH_D64 - 1))) >> bec_pkg::SH_D64;

  always_comb begin
    case (c_arc_q)
      bec_pkg::ARC_FIRST:     f_val = signed'(sq_d16[F_W-1:0]);
      bec_pkg::ARC_FIRST_ALT: f_val = signed'(sq_d4[F_W-1:0]) - bec_pkg::F_ONE;
      bec_pkg::ARC_SECOND:    f_val = signed'(sq_d16[F_W-1:0]) - bec_pkg::F_QUARTER;
      bec_pkg::ARC_THIRD:     f_val = signed'(sq_d16[F_W-1:0]) - bec_pkg::F_SIXTEENTH;
      bec_pkg::ARC_LAST:      f_val = signed'(sq_d64[F_W-1:0]) - bec_pkg::F_SIXTYFOUR;
      default:                f_val = '0;
    endcase
  end

  assign swing    = C_W'(end_q) - C_W'(start_q);
  assign amp_sel  = amp_en_q ? C_W'(amp_q) : swing;
  assign mult_sel = (c_arc_q == bec_pkg::ARC_FIRST) ? swing : amp_sel;
  assign base_sel = ((c_arc_q == bec_pkg::ARC_FIRST) || (c_arc_q == bec_pkg::ARC_FIRST_ALT))
                    ? '0 : swing;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_f_q    <= f_val;
      d_mult_q <= mult_sel;
      d_base_q <= base_sel;
    end
  end

  // ---------------------------------------------------------------
  // stage E: split into sign and magnitudes
  // ---------------------------------------------------------------
  logic [MW-1:0]         e_am_q;
  logic [FM_W-1:0]       e_fm_q;
  logic                  e_neg_q;
  logic signed [C_W-1:0] e_base_q;
  logic [F_W-1:0]        f_abs;

  assign f_abs = d_f_q[F_W-1] ? F_W'(-d_f_q) : F_W'(d_f_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_am_q   <= d_mult_q[C_W-1] ? MW'(-d_mult_q) : MW'(d_mult_q);
      e_fm_q   <= f_abs[FM_W-1:0];
      e_neg_q  <= d_mult_q[C_W-1] ^ d_f_q[F_W-1];
      e_base_q <= d_base_q;
    end
  end

  // ---------------------------------------------------------------
  // stage F: two partial products of multiplier times factor
  // ---------------------------------------------------------------
  logic [HI_W+FM_W-1:0]  f_ph_q;
  logic [LO_W+FM_W-1:0]  f_pl_q;
  logic                  f_neg_q;
  logic signed [C_W-1:0] f_base_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_ph_q   <= (HI_W + FM_W)'(e_am_q[MW-1:LO_W]) * (HI_W + FM_W)'(e_fm_q);
      f_pl_q   <= (LO_W + FM_W)'(e_am_q[LO_W-1:0]) * (LO_W + FM_W)'(e_fm_q);
      f_neg_q  <= e_neg_q;
      f_base_q <= e_base_q;
    end
  end

  // ---------------------------------------------------------------
  // stage G: combine, round half up on the magnitude, drop Q30
  // ---------------------------------------------------------------
  logic [PROD_W-1:0]     prod;
  logic [MW-1:0]         g_mag_q;
  logic                  g_neg_q;
  logic signed [C_W-1:0] g_base_q;

  assign prod = (PROD_W'(f_ph_q) << LO_W) + PROD_W'(f_pl_q)
              + (PROD_W'(1) << (FRAC_F - 1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_mag_q  <= prod[FRAC_F +: MW];
      g_neg_q  <= f_neg_q;
      g_base_q <= f_base_q;
    end
  end

  // ---------------------------------------------------------------
  // stage H: r = base + signed term
  // ---------------------------------------------------------------
  logic signed [V_W-1:0] h_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_r_q <= g_neg_q ? (V_W'(g_base_q) - signed'(V_W'(g_mag_q)))
                       : (V_W'(g_base_q) + signed'(V_W'(g_mag_q)));
    end
  end

  // ---------------------------------------------------------------
  // stage I: place on start or end, saturate
  // ---------------------------------------------------------------
  logic signed [V_W-1:0] val;
  logic                  fits;
  logic signed [VW-1:0]  val_sat;
  logic signed [VW-1:0]  i_val_q;

  assign val  = ease_q ? (V_W'(end_q) - h_r_q) : (V_W'(start_q) + h_r_q);
  assign fits = (&val[V_W-1:VW-1]) || !(|val[V_W-1:VW-1]);

  always_comb begin
    if (fits) begin
      val_sat = val[VW-1:0];
    end else if (val[V_W-1]) begin
      val_sat = {1'b1, {(VW - 1){1'b0}}};
    end else begin
      val_sat = {1'b0, {(VW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_val_q <= val_sat;
    end
  end

  // ---------------------------------------------------------------
  // output skid register: catches the last stage on a stall
  // ---------------------------------------------------------------
  logic signed [VW-1:0] skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_ch.ready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (vld_q[DEPTH-1] && !out_ch.ready) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_q <= i_val_q;
    end
  end

  assign out_ch.valid       = skid_vld_q || vld_q[DEPTH-1];
  assign out_ch.eased_value = skid_vld_q ? skid_q : i_val_q;

endmodule

[src/bec_checker.sv]
// Port-level checks of the bounce easing curve block, bound to its top level.
module bec_checker #(
  parameter int unsigned VALUE_WIDTH = bec_pkg::VALUE_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [VALUE_WIDTH-1:0] out_value_i,
  input logic                          cfg_ready_i
);

  localparam int unsigned MAX_ITEMS = bec_pkg::PIPE_DEPTH + 1;
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1) + 1;

  // items accepted and not yet delivered
  logic [CNT_W-1:0] inflight_q;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // a stalled result stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("stalled result changed or dropped");

  // input is refused only while a result waits on the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input refused with no result waiting");

  // no result without an item in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != '0)
    else $error("result offered with no item in flight");

  // pipeline plus skid register bounds the items in flight
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(MAX_ITEMS))
    else $error("more items in flight than the pipeline holds");

  // register writes are never refused
  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("register write refused");

endmodule

bind bounce_easing_curve_top bec_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_bec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_value_i (out_ch.eased_value),
  .cfg_ready_i (cfg_ch.ready)
);

[tb/bounce_easing_curve_top_test.sv]
// Self-checking testbench for the bounce easing curve block, with random flow control.
`timescale 1ns / 100ps

module bounce_easing_curve_top_test;

  localparam int     CYCLE_LIMIT     = 200000;
  localparam int     RAND_PHASES     = 12;
  localparam int     ITEMS_PER_PHASE = 160;
  localparam int     PRESSURE_PHASE  = 3;
  localparam int     QUIET_PHASE     = 7;
  localparam int     HOLD_CYCLES     = 300;
  localparam int     IDLE_PCT        = 33;
  localparam int     MAX_PRINTED     = 20;
  localparam longint Q30_ONE         = longint'(1) << 30;
  localparam longint U_ONE           = longint'(bec_pkg::Q_ONE);
  localparam longint VALUE_MAX       = 64'sd2147483647;
  localparam longint VALUE_MIN       = -64'sd2147483648;

  // indexes with no register behind them
  localparam logic [bec_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bec_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Curve predictor with its own register copy and the queue of pending values
  class bounce_scoreboard;
    typedef struct {
      logic [15:0]        t;
      logic signed [31:0] value;
    } pending_value_t;

    logic signed [31:0] start_v;
    logic signed [31:0] end_v;
    logic signed [31:0] amp_v;
    logic [15:0]        dur_v;
    bit                 ease_in_v;
    bit                 amp_en_v;
    pending_value_t     pending_q[$];
    int unsigned        n_checked;
    int unsigned        n_errors;

    function new();
      start_v   = '0;
      end_v     = bec_pkg::Q_ONE;
      dur_v     = 16'd1;
      ease_in_v = 1'b0;
      amp_en_v  = 1'b0;
      amp_v     = '0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function void apply_reg(logic [bec_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        bec_pkg::REG_START:      start_v = data;
        bec_pkg::REG_END:        end_v = data;
        bec_pkg::REG_DURATION:   dur_v = data[15:0];
        bec_pkg::REG_EASE_IN:    ease_in_v = data[0];
        bec_pkg::REG_AMP_ENABLE: amp_en_v = data[0];
        bec_pkg::REG_AMPLITUDE:  amp_v = data;
        default: ;
      endcase
    endfunction

    // square of an offset, divided by 4*den, rounded half up
    function longint sq_round(longint d, int den);
      longint m;
      m = (d < 0) ? -d : d;
      return (m * m + 2 * longint'(den)) / (4 * longint'(den));
    endfunction

    // a * f / 2^30, rounded half away from zero
    function longint scale_round(longint a, longint fq);
      longint unsigned am, fm, mag;
      am  = (a < 0) ? -a : a;
      fm  = (fq < 0) ? -fq : fq;
      mag = (am * fm + (64'd1 << 29)) >> 30;
      return ((a < 0) != (fq < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    function logic signed [31:0] eased_at(logic [15:0] t);
      longint b, e, c, amp, span, tt, u, n11, f, mult, base, r, v;
      bec_pkg::arc_e arc;
      b    = longint'(start_v);
      e    = longint'(end_v);
      c    = e - b;
      amp  = amp_en_v ? longint'(amp_v) : c;
      span = longint'(dur_v);
      if (span == 0) span = 1;
      tt = longint'(t);
      if (tt > span) tt = span;
      if (ease_in_v) tt = span - tt;
      u   = (tt << 16) / span;
      n11 = 11 * u;

      // arc selection on 11*u
      if (n11 < 4 * U_ONE) begin
        arc = (c == 0 && amp_en_v) ? bec_pkg::ARC_FIRST_ALT : bec_pkg::ARC_FIRST;
      end else if (n11 < 8 * U_ONE) begin
        arc = bec_pkg::ARC_SECOND;
      end else if (n11 < 10 * U_ONE) begin
        arc = bec_pkg::ARC_THIRD;
      end else begin
        arc = bec_pkg::ARC_LAST;
      end

      // Q30 factor, multiplier and base per arc
      base = c;
      mult = amp;
      case (arc)
        bec_pkg::ARC_FIRST: begin
          f    = sq_round(n11, 16);
          mult = c;
          base = 0;
        end
        bec_pkg::ARC_FIRST_ALT: begin
          f    = sq_round(n11 - 2 * U_ONE, 4) - Q30_ONE;
          base = 0;
        end
        bec_pkg::ARC_SECOND: f = sq_round(n11 - 6 * U_ONE, 16) - (Q30_ONE >> 2);
        bec_pkg::ARC_THIRD:  f = sq_round(n11 - 9 * U_ONE, 16) - (Q30_ONE >> 4);
        default:             f = sq_round(2 * n11 - 21 * U_ONE, 64) - (Q30_ONE >> 6);
      endcase

      r = base + scale_round(mult, f);
      v = ease_in_v ? e - r : b + r;
      if (v > VALUE_MAX) v = VALUE_MAX;
      if (v < VALUE_MIN) v = VALUE_MIN;
      return v[31:0];
    endfunction

    function void note_time(logic [15:0] t);
      pending_value_t p;
      p.t     = t;
      p.value = eased_at(t);
      pending_q.push_back(p);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      if (n_errors <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_value(logic signed [31:0] got);
      pending_value_t p;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("eased_value %0d with no item outstanding", got));
        return;
      end
      p = pending_q.pop_front();
      n_checked++;
      if (got !== p.value)
        report_mismatch($sformatf("t=%0d eased_value got %0d want %0d", p.t, got, p.value));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  bec_time_if  #(.TIME_WIDTH(bec_pkg::TIME_WIDTH_DEF))   in_ch  ();
  bec_value_if #(.VALUE_WIDTH(bec_pkg::VALUE_WIDTH_DEF)) out_ch ();
  bec_cfg_if   #(.DATA_WIDTH(bec_pkg::CFG_DATA_W_DEF))   cfg_ch ();

  bounce_easing_curve_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bounce_scoreboard sb;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               hold_left;
  int               cur_span;
  int               n_settings;
  int               phase_idx;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d values still outstanding", CYCLE_LIMIT,
             sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stalls plus a long hold when asked
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Handshake monitor: register writes, accepted times, returned values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.apply_reg(cfg_ch.index, cfg_ch.wdata);
      if (in_ch.valid && in_ch.ready) sb.note_time(in_ch.elapsed_time);
      if (out_ch.valid && out_ch.ready) sb.check_value(out_ch.eased_value);
    end
  end

  // Offer one time item and hold it until accepted; maybe pause afterwards
  task automatic send_time(input logic [15:0] t);
    in_ch.valid        <= 1'b1;
    in_ch.elapsed_time <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Register write; valid stays high so back-to-back writes need no gap
  task automatic cfg_write(input logic [bec_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Wait for every outstanding value, then a few more cycles
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_curve(input logic [31:0] s, input logic [31:0] e,
                           input logic [15:0] d, input bit ease, input bit amp_en,
                           input logic [31:0] amp);
    settle();
    cfg_write(bec_pkg::REG_START, s);
    cfg_write(bec_pkg::REG_END, e);
    cfg_write(bec_pkg::REG_DURATION, {16'd0, d});
    cfg_write(bec_pkg::REG_EASE_IN, {31'd0, ease});
    cfg_write(bec_pkg::REG_AMP_ENABLE, {31'd0, amp_en});
    cfg_write(bec_pkg::REG_AMPLITUDE, amp);
    cfg_ch.valid <= 1'b0;
    cur_span = (d == 0) ? 1 : int'(d);
    n_settings++;
  endtask

  // Value mix: limits, small Q16.16 numbers, anything
  function automatic logic [31:0] pick_value();
    int k;
    k = int'($urandom_range(0, 20 * bec_pkg::Q_ONE)) - 10 * bec_pkg::Q_ONE;
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom;
      default: return k;
    endcase
  endfunction

  function automatic logic [15:0] pick_duration();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hffff;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(2, 1500));
    endcase
  endfunction

  // Mostly inside the curve, some past its end
  function automatic logic [15:0] pick_time();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(cur_span, 65535));
      default: return 16'($urandom_range(0, cur_span));
    endcase
  endfunction

  task automatic random_curve();
    logic [31:0] s;
    logic [31:0] e;
    s = pick_value();
    e = ($urandom_range(3) == 0) ? s : pick_value();
    set_curve(s, e, pick_duration(), 1'($urandom_range(1)), 1'($urandom_range(1)),
              pick_value());
  endtask

  // Stimulus
  initial begin
    sb                 = new();
    tx_idle_pct        = IDLE_PCT;
    rx_idle_pct        = IDLE_PCT;
    hold_left          = 0;
    cur_span           = 1;
    n_settings         = 1;
    rst_ni             <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.elapsed_time <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= bec_pkg::REG_START;
    cfg_ch.wdata       <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register values after reset
    send_time(16'd0);
    send_time(16'd1);
    send_time(16'hffff);
    in_ch.valid <= 1'b0;

    // unit swing over 1100 ms: near each arc boundary and past the end
    set_curve(32'd0, bec_pkg::Q_ONE, 16'd1100, 1'b0, 1'b0, 32'd0);
    send_time(16'd0);
    send_time(16'd399);
    send_time(16'd400);
    send_time(16'd799);
    send_time(16'd800);
    send_time(16'd999);
    send_time(16'd1000);
    send_time(16'd1100);
    send_time(16'hffff);
    in_ch.valid <= 1'b0;

    // mirrored in time
    set_curve(32'd0, bec_pkg::Q_ONE, 16'd1100, 1'b1, 1'b0, 32'd0);
    send_time(16'd0);
    send_time(16'd100);
    send_time(16'd300);
    send_time(16'd1100);
    in_ch.valid <= 1'b0;

    // zero swing with amplitude override takes the alternate first arc
    set_curve(3 * bec_pkg::Q_ONE, 3 * bec_pkg::Q_ONE, 16'd1100, 1'b0, 1'b1,
              -2 * bec_pkg::Q_ONE);
    send_time(16'd0);
    send_time(16'd200);
    send_time(16'd399);
    send_time(16'd700);
    in_ch.valid <= 1'b0;

    // full-range swing and amplitude: saturation
    set_curve(32'h8000_0000, 32'h7fff_ffff, 16'hffff, 1'b0, 1'b1, 32'h8000_0000);
    send_time(16'd0);
    send_time(16'd30000);
    send_time(16'hffff);
    in_ch.valid <= 1'b0;

    // zero duration acts as one; writes to unused indexes change nothing
    set_curve(-bec_pkg::Q_ONE, 5 * bec_pkg::Q_ONE, 16'd0, 1'b1, 1'b0, 32'h7fff_ffff);
    @(posedge clk_i);
    cfg_write(REG_SPARE_LO, 32'hffff_ffff);
    cfg_write(REG_SPARE_HI, 32'hffff_ffff);
    cfg_ch.valid <= 1'b0;
    send_time(16'd0);
    send_time(16'hffff);
    in_ch.valid <= 1'b0;

    // random settings and times
    for (phase_idx = 0; phase_idx < RAND_PHASES; phase_idx++) begin
      random_curve();
      if (phase_idx == PRESSURE_PHASE) begin
        tx_idle_pct = 0;
        hold_left   = HOLD_CYCLES;
      end
      if (phase_idx == QUIET_PHASE) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      repeat (ITEMS_PER_PHASE) send_time(pick_time());
      in_ch.valid <= 1'b0;
      tx_idle_pct = IDLE_PCT;
      rx_idle_pct = IDLE_PCT;
    end

    // drain and let the pipeline run empty
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (bec_pkg::PIPE_DEPTH + 8) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d values never returned", sb.pending()));

    $display("checked %0d eased values over %0d register settings, %0d mismatches",
             sb.n_checked, n_settings, sb.n_errors);
    $display("covered out/in modes, amplitude override, zero swing, saturation, zero duration");
    if (sb.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
